// ===== rtl/core/cgi_pkg.sv =====
package cgi_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned MAX_STOPS     = 6;
  localparam int unsigned STOP_REGS     = 6;

  localparam int unsigned IDX_W     = 10;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned CHANNELS  = 3;
  localparam int unsigned COLOR_W   = CHANNELS * CH_W;
  localparam int unsigned STOP_W    = POS_W + COLOR_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = STOP_W;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned SEG_W     = 3;
  localparam int unsigned IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned PROD_W    = POS_W + CH_W;

  localparam logic [CH_W-1:0] ALPHA = 8'hFF;
  localparam int unsigned POS_ONE   = 65535;

  // position t = idx * POS_ONE / LAST via reciprocal multiply and one correction
  localparam longint unsigned LAST        = TABLE_ENTRIES - 1;
  localparam int unsigned     X_W         = IDX_W + POS_W;
  localparam int unsigned     RECIP_SHIFT = X_W;
  localparam longint unsigned RECIP       = (64'd1 << RECIP_SHIFT) / LAST;
  localparam longint unsigned KMUL        = RECIP * POS_ONE;
  localparam int unsigned     KMUL_W      = $clog2(KMUL + 1);
  localparam int unsigned     KPROD_W     = IDX_W + KMUL_W;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BASE  = 3'd1;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [STOP_W-1:0]  stop_t;

  typedef struct packed {
    pos_t   t;
    pos_t   pa;
    pos_t   pb;
    color_t ca;
    color_t cb;
  } seg_req_t;

  function automatic pos_t stop_pos(stop_t w);
    return w[STOP_W-1:COLOR_W];
  endfunction

  function automatic color_t stop_color(stop_t w);
    return w[COLOR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/color_gradient_interpolator.sv =====
// a request passes the position divide, the segment select and the 8-stage
// quotient pipeline before its result is valid
// throughput: one request per cycle while the output is ready; output stalls
// freeze the blend pipeline, fill the queue and then hold off the input
// reset: asynchronous active low, clears all pipelines and the queue and loads
// two stops, black at position 0 and white at position one
module color_gradient_interpolator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cgi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cgi_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cgi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // entry_index
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cgi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // color_word
);
  import cgi_pkg::*;

  logic     full, push, empty, pop;
  seg_req_t req_in, req_out;

  cgi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_index_i (s_axis_tdata[IDX_W-1:0]),
    .full_i     (full),
    .push_o     (push),
    .req_o      (req_in)
  );

  cgi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (req_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (req_out)
  );

  cgi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .req_i       (req_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_color_o (m_axis_tdata)
  );

endmodule

// ===== rtl/core/cgi_front.sv =====
module cgi_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cgi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cgi_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cgi_pkg::IDX_W-1:0]        in_index_i,
  input  logic                             full_i,
  output logic                             push_o,
  output cgi_pkg::seg_req_t                req_o
);
  import cgi_pkg::*;

  logic [COUNT_W-1:0] stop_count_q;
  stop_t              stop_q [STOP_REGS];

  logic               v1_q, v2_q, v3_q;
  logic               en;
  logic [IDX_W-1:0]   idx_sat;
  logic [IDX_W-1:0]   idx1_q;
  logic [KPROD_W-1:0] kprod_d, kprod_q;
  pos_t               t_d, t_q;
  seg_req_t           req_d, req_q;

  logic [X_W-1:0]     x;
  logic [X_W-1:0]     r;
  pos_t               q0;
  logic [COUNT_W-1:0] n;
  logic [SEG_W-1:0]   seg;

  assign en         = !v3_q || !full_i;
  assign in_ready_o = en;
  assign push_o     = v3_q && !full_i;
  assign req_o      = req_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= COUNT_W'(2);
      for (int k = 0; k < STOP_REGS; k++) begin
        stop_q[k] <= (k == 1) ? {STOP_W{1'b1}} : {STOP_W{1'b0}};
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_STOP_COUNT) begin
        stop_count_q <= cfg_data_i[COUNT_W-1:0];
      end else if ((cfg_idx_i >= REG_STOP_BASE) &&
                   ({1'b0, cfg_idx_i} < ({1'b0, REG_STOP_BASE} + (CFG_IDX_W+1)'(STOP_REGS))))
      begin
        stop_q[CFG_IDX_W'(cfg_idx_i - REG_STOP_BASE)] <= cfg_data_i[STOP_W-1:0];
      end
    end
  end

  // stage 1: saturate index and multiply by scaled reciprocal
  always_comb begin
    idx_sat = in_index_i;
    if (longint'(in_index_i) > LAST) begin
      idx_sat = IDX_W'(LAST);
    end
    kprod_d = KPROD_W'(idx_sat) * KPROD_W'(KMUL);
  end

  // stage 2: correct the quotient estimate
  always_comb begin
    q0  = POS_W'(kprod_q >> RECIP_SHIFT);
    x   = X_W'(idx1_q) * X_W'(POS_ONE);
    r   = x - X_W'(q0) * X_W'(LAST);
    t_d = (r >= X_W'(LAST)) ? q0 + POS_W'(1) : q0;
  end

  // stage 3: segment select
  always_comb begin
    n = stop_count_q;
    if (n < COUNT_W'(2)) begin
      n = COUNT_W'(2);
    end
    if (n > COUNT_W'(MAX_STOPS)) begin
      n = COUNT_W'(MAX_STOPS);
    end
    seg = SEG_W'(n - COUNT_W'(2));
    for (int s = MAX_STOPS - 2; s >= 0; s--) begin
      if (((s + 1) < int'(n)) && (t_q <= stop_pos(stop_q[s+1]))) begin
        seg = SEG_W'(s);
      end
    end
    req_d.t  = t_q;
    req_d.pa = '0;
    req_d.pb = '0;
    req_d.ca = '0;
    req_d.cb = '0;
    for (int s = 0; s < MAX_STOPS - 1; s++) begin
      if (seg == SEG_W'(s)) begin
        req_d.pa = stop_pos(stop_q[s]);
        req_d.pb = stop_pos(stop_q[s+1]);
        req_d.ca = stop_color(stop_q[s]);
        req_d.cb = stop_color(stop_q[s+1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q  <= idx_sat;
      kprod_q <= kprod_d;
      t_q     <= t_d;
      req_q   <= req_d;
    end
  end

endmodule

// ===== rtl/core/cgi_fifo.sv =====
module cgi_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cgi_pkg::seg_req_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output cgi_pkg::seg_req_t data_o
);
  import cgi_pkg::*;

  seg_req_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // depth is a power of two, pointers wrap naturally
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (FIFO_AW+1)'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/cgi_back.sv =====
module cgi_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  cgi_pkg::seg_req_t                req_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cgi_pkg::OUT_TDATA_W-1:0]  out_color_o
);
  import cgi_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] lo;
    logic [CH_W-1:0] mag;
    logic            neg;
  } chan_t;

  typedef struct packed {
    pos_t                  num;
    pos_t                  span;
    chan_t [CHANNELS-1:0]  ch;
  } blend_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [CH_W-1:0]   quo;
    logic [CH_W-1:0]   lo;
    logic              neg;
  } lane_t;

  typedef struct packed {
    pos_t                  span;
    lane_t [CHANNELS-1:0]  lane;
  } div_t;

  logic                  en;
  logic                  b0_v_q, b1_v_q, out_v_q;
  logic [CH_W-1:0]       div_v_q;
  blend_t                b0_d, b0_q;
  div_t                  b1_d, b1_q;
  div_t                  div_d [CH_W];
  div_t                  div_q [CH_W];
  logic [OUT_TDATA_W-1:0] out_d, out_q;

  function automatic div_t div_step(div_t s, int unsigned b);
    div_t              o;
    logic [PROD_W-1:0] dsr;
    o   = s;
    dsr = PROD_W'(s.span) << b;
    for (int c = 0; c < CHANNELS; c++) begin
      if (s.lane[c].rem >= dsr) begin
        o.lane[c].rem    = s.lane[c].rem - dsr;
        o.lane[c].quo[b] = 1'b1;
      end
    end
    return o;
  endfunction

  assign en          = !out_v_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_v_q;
  assign out_color_o = out_q;

  // numerator and span of the fraction, channel deltas
  always_comb begin
    b0_d.num  = '0;
    b0_d.span = POS_W'(1);
    if (req_i.pb > req_i.pa) begin
      b0_d.span = req_i.pb - req_i.pa;
      if (req_i.t >= req_i.pb) begin
        b0_d.num = b0_d.span;
      end else if (req_i.t > req_i.pa) begin
        b0_d.num = req_i.t - req_i.pa;
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      b0_d.ch[c].lo  = req_i.ca[c*CH_W +: CH_W];
      b0_d.ch[c].neg = req_i.cb[c*CH_W +: CH_W] < req_i.ca[c*CH_W +: CH_W];
      b0_d.ch[c].mag = b0_d.ch[c].neg ?
                       req_i.ca[c*CH_W +: CH_W] - req_i.cb[c*CH_W +: CH_W] :
                       req_i.cb[c*CH_W +: CH_W] - req_i.ca[c*CH_W +: CH_W];
    end
  end

  always_comb begin
    b1_d.span = b0_q.span;
    for (int c = 0; c < CHANNELS; c++) begin
      b1_d.lane[c].rem = PROD_W'(b0_q.num) * PROD_W'(b0_q.ch[c].mag);
      b1_d.lane[c].quo = '0;
      b1_d.lane[c].lo  = b0_q.ch[c].lo;
      b1_d.lane[c].neg = b0_q.ch[c].neg;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    div_d[0] = div_step(b1_q, CH_W - 1);
    for (int i = 1; i < CH_W; i++) begin
      div_d[i] = div_step(div_q[i-1], CH_W - 1 - i);
    end
  end

  // falling channels take the ceiling so the result stays floored
  always_comb begin
    out_d = '0;
    out_d[OUT_TDATA_W-1 -: CH_W] = ALPHA;
    for (int c = 0; c < CHANNELS; c++) begin
      if (div_q[CH_W-1].lane[c].neg) begin
        out_d[c*CH_W +: CH_W] = div_q[CH_W-1].lane[c].lo - div_q[CH_W-1].lane[c].quo -
                                CH_W'(div_q[CH_W-1].lane[c].rem != '0);
      end else begin
        out_d[c*CH_W +: CH_W] = div_q[CH_W-1].lane[c].lo + div_q[CH_W-1].lane[c].quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q  <= 1'b0;
      b1_v_q  <= 1'b0;
      div_v_q <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b0_v_q  <= !empty_i;
      b1_v_q  <= b0_v_q;
      div_v_q <= {div_v_q[CH_W-2:0], b1_v_q};
      out_v_q <= div_v_q[CH_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q  <= b0_d;
      b1_q  <= b1_d;
      for (int i = 0; i < CH_W; i++) begin
        div_q[i] <= div_d[i];
      end
      out_q <= out_d;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cgi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 115;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] sel;
    logic [CFG_W-1:0]     data;
    logic [IDX_W-1:0]     idx;
    logic                 typed;
    logic [31:0]          want;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // entry_index
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // color_word

  // shadow of the gradient registers
  logic [COUNT_W-1:0] cfg_count;
  logic [STOP_W-1:0]  cfg_stop [STOP_REGS];

  logic [31:0] color_q [$];
  plan_row_t   plan_q [$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          idle_on      = 1'b1;
  bit          row_typed    = 1'b0;
  logic [31:0] row_want     = '0;

  color_gradient_interpolator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [STOP_W-1:0] stop_word(logic [POS_W-1:0] pos,
                                                   logic [COLOR_W-1:0] bgr);
    return {pos, bgr};
  endfunction

  // piecewise-linear color for one index under the shadow registers
  function automatic logic [31:0] grad_color(logic [IDX_W-1:0] idx);
    longint t, pa, pb, span, num, lo, hi;
    int n, seg, s, c;
    logic [STOP_W-1:0]  wa, wb;
    logic [COLOR_W-1:0] bgr;
    t = longint'((longint'(idx) * POS_ONE) / LAST);
    n = int'(cfg_count);
    if (n < 2) n = 2;
    if (n > int'(MAX_STOPS)) n = int'(MAX_STOPS);
    seg = n - 2;
    for (s = n - 2; s >= 0; s--) begin
      if (t <= longint'(cfg_stop[s+1][STOP_W-1:COLOR_W])) seg = s;
    end
    wa = cfg_stop[seg];
    wb = cfg_stop[seg+1];
    pa = longint'(wa[STOP_W-1:COLOR_W]);
    pb = longint'(wb[STOP_W-1:COLOR_W]);
    span = pb - pa;
    if (span <= 0) begin
      span = 1;
      num = 0;
    end else begin
      num = t - pa;
      if (num < 0) num = 0;
      if (num > span) num = span;
    end
    for (c = 0; c < int'(CHANNELS); c++) begin
      lo = longint'(wa[c*CH_W +: CH_W]);
      hi = longint'(wb[c*CH_W +: CH_W]);
      bgr[c*CH_W +: CH_W] = CH_W'((lo * span + num * (hi - lo)) / span);
    end
    return {ALPHA, bgr};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // request and color monitor
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        color_q.push_back(row_typed ? row_want : grad_color(s_axis_tdata[IDX_W-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (color_q.size() == 0) begin
          report_mismatch("color with no request pending", m_axis_tdata, '0);
        end else begin
          want = color_q.pop_front();
          if (m_axis_tdata !== want) report_mismatch("color_word", m_axis_tdata, want);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // output stalls
  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && idle_on && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 3);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    if (sel == REG_STOP_COUNT)
      cfg_count = data[COUNT_W-1:0];
    else if (sel != REG_UNUSED)
      cfg_stop[sel - REG_STOP_BASE] = data[STOP_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_index(logic [IDX_W-1:0] idx, bit typed, logic [31:0] want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(idx);
    row_typed = typed;
    row_want  = want;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] data);
    plan_q.push_back('{is_cfg: 1'b1, sel: sel, data: data, idx: '0, typed: 1'b0, want: '0});
  endfunction

  function automatic void plan_item(logic [IDX_W-1:0] idx, bit typed = 1'b0,
                                    logic [31:0] want = '0);
    plan_q.push_back('{is_cfg: 1'b0, sel: '0, data: '0, idx: idx, typed: typed, want: want});
  endfunction

  // stops in rising order, or raw noise words
  task automatic load_gradient(bit neat);
    int n, p, k;
    logic [CFG_W-1:0] w;
    n = neat ? $urandom_range(2, MAX_STOPS) : $urandom_range(0, 7);
    p = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6000);
    for (k = 0; k < int'(STOP_REGS); k++) begin
      if (neat) begin
        if (k == n - 1 && $urandom_range(0, 1) == 1) p = int'(POS_ONE);
        w = stop_word(POS_W'(p), COLOR_W'($urandom));
        p = p + $urandom_range(0, 65535 / (n - 1) + 2000);
        if (p > int'(POS_ONE)) p = int'(POS_ONE);
      end else begin
        w = CFG_W'({$urandom, $urandom});
      end
      cfg_write(CFG_IDX_W'(REG_STOP_BASE + k), w);
    end
    cfg_write(REG_STOP_COUNT, CFG_W'(n));
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int v, k;
    v = $urandom_range(0, 19);
    if (v == 0) return '0;
    if (v == 1) return IDX_W'(LAST);
    if (v < 6) begin
      k = $urandom_range(0, STOP_REGS - 1);
      v = int'(cfg_stop[k][STOP_W-1:COLOR_W]) * int'(LAST) / int'(POS_ONE)
          + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > int'(LAST)) v = int'(LAST);
      return IDX_W'(v);
    end
    return IDX_W'($urandom_range(0, int'(LAST)));
  endfunction

  initial begin
    int r, ph, i, k;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_count     = COUNT_W'(2);
    for (k = 0; k < int'(STOP_REGS); k++) cfg_stop[k] = '0;
    cfg_stop[1] = '1;

    // reset gradient, black to white
    plan_item(10'd0, 1'b1, 32'hFF000000);
    plan_item(10'd1023, 1'b1, 32'hFFFFFFFF);
    plan_item(10'd511);
    plan_item(10'd512);
    plan_item(10'd1);
    // stop count too small
    plan_cfg(REG_STOP_COUNT, CFG_W'(0));
    plan_item(10'd1023, 1'b1, 32'hFFFFFFFF);
    plan_item(10'd0, 1'b1, 32'hFF000000);
    // six stops, last segment reversed, count too large
    plan_cfg(REG_STOP_BASE + 3'd0, stop_word(16'h1000, 24'h102030));
    plan_cfg(REG_STOP_BASE + 3'd1, stop_word(16'h8000, 24'h405060));
    plan_cfg(REG_STOP_BASE + 3'd2, stop_word(16'hC000, 24'hA0B0C0));
    plan_cfg(REG_STOP_BASE + 3'd3, stop_word(16'hE000, 24'hFF00FF));
    plan_cfg(REG_STOP_BASE + 3'd4, stop_word(16'hF000, 24'h00FF00));
    plan_cfg(REG_STOP_BASE + 3'd5, stop_word(16'hE800, 24'h0000FF));
    plan_cfg(REG_STOP_COUNT, CFG_W'(7));
    plan_item(10'd0, 1'b1, 32'hFF102030);
    plan_item(10'd1023, 1'b1, 32'hFF00FF00);
    plan_item(10'd600);
    plan_item(10'd800);
    plan_item(10'd900);
    plan_item(10'd511);
    plan_item(10'd512);
    // position at the upper stop
    plan_cfg(REG_STOP_BASE + 3'd5, stop_word(16'hFFFF, 24'hFFFFFF));
    plan_cfg(REG_STOP_COUNT, CFG_W'(6));
    plan_item(10'd1023, 1'b1, 32'hFFFFFFFF);
    // empty segment
    plan_cfg(REG_STOP_BASE + 3'd0, stop_word(16'h4000, 24'h112233));
    plan_cfg(REG_STOP_BASE + 3'd1, stop_word(16'h4000, 24'h445566));
    plan_cfg(REG_STOP_COUNT, CFG_W'(1));
    plan_item(10'd1023, 1'b1, 32'hFF112233);
    plan_item(10'd0, 1'b1, 32'hFF112233);
    // write to an unused register index
    plan_cfg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
    plan_item(10'd512, 1'b1, 32'hFF112233);
    // all-ones and all-zero stop words
    plan_cfg(REG_STOP_BASE + 3'd0, '1);
    plan_cfg(REG_STOP_BASE + 3'd1, '1);
    plan_item(10'd300, 1'b1, 32'hFFFFFFFF);
    plan_cfg(REG_STOP_BASE + 3'd0, '0);
    plan_cfg(REG_STOP_BASE + 3'd1, '0);
    plan_item(10'd700, 1'b1, 32'hFF000000);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (r = 0; r < plan_q.size(); r++) begin
      if (plan_q[r].is_cfg)
        cfg_write(plan_q[r].sel, plan_q[r].data);
      else
        send_index(plan_q[r].idx, plan_q[r].typed, plan_q[r].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 1 || ph == 2) begin
        for (k = 0; k < int'(STOP_REGS); k++)
          cfg_write(CFG_IDX_W'(REG_STOP_BASE + k), (ph == 1) ? '0 : '1);
        cfg_write(REG_STOP_COUNT, CFG_W'((ph == 1) ? 6 : 7));
      end else begin
        load_gradient($urandom_range(0, 9) < 7);
      end
      if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, CFG_W'({$urandom, $urandom}));
      idle_on = (ph < PHASES - 2) && (ph % 3 != 1);
      for (i = 0; i < PHASE_ITEMS; i++) send_index(pick_index(), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
